>>> hdl/keypad_debounce_repeat_queue_top_macros.svh
// Assertion macros for the keypad debounce and repeat queue.
// Used by keypad_debounce_repeat_queue_top; expects signals named clock and reset in scope.
`ifndef KEYPAD_DEBOUNCE_REPEAT_QUEUE_TOP_MACROS_SVH
`define KEYPAD_DEBOUNCE_REPEAT_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define KDRQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define KDRQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/kdrq_pkg.sv
// Shared types and constants for the keypad debounce and repeat queue.
// No dependencies; used by kdrq_code_ram and keypad_debounce_repeat_queue_top.
`timescale 1ns / 1ps

package kdrq_pkg;

   typedef logic [3:0] key_code_type;
   typedef logic [3:0] key_bits_type;

   // queued key codes
   localparam key_code_type CODE_NONE     = 4'd0;
   localparam key_code_type CODE_UP       = 4'd1;
   localparam key_code_type CODE_DOWN     = 4'd2;
   localparam key_code_type CODE_ESC      = 4'd3;
   localparam key_code_type CODE_ENTER    = 4'd4;
   localparam key_code_type CODE_UPDOWN   = 4'd5;
   localparam key_code_type CODE_ESCENTER = 4'd6;
   localparam key_code_type CODE_UPOFF    = 4'd7;
   localparam key_code_type CODE_DOWNOFF  = 4'd8;

   // bit positions of the qualified key pattern
   localparam int KEY_ESC   = 0;
   localparam int KEY_UP    = 1;
   localparam int KEY_DOWN  = 2;
   localparam int KEY_ENTER = 3;

   // raw bytes that count as a key
   localparam logic [7:0] RAW_ESC   = 8'd1;
   localparam logic [7:0] RAW_UP    = 8'd2;
   localparam logic [7:0] RAW_DOWN  = 8'd4;
   localparam logic [7:0] RAW_ENTER = 8'd8;

   // transaction function codes
   localparam logic FUNC_SCAN = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_DEBOUNCE_TICKS = 2'd0,
      CSR_REPEAT_DELAY   = 2'd1,
      CSR_REPEAT_RELOAD  = 2'd2
   } csr_index_type;

   localparam logic [7:0] DEBOUNCE_TICKS_RESET = 8'd10;
   localparam logic [7:0] REPEAT_DELAY_RESET   = 8'd100;
   localparam logic [7:0] REPEAT_RELOAD_RESET  = 8'd80;
   localparam logic [7:0] COUNT_MAX            = 8'hFF;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

endpackage

>>> hdl/kdrq_code_ram.sv
// Two-bank key code store: entries alternate banks by push order so two codes
// can be written in one cycle. Depends on kdrq_pkg.
`timescale 1ns / 1ps

module kdrq_code_ram #(
   parameter int DEPTH  = kdrq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int ADDR_W = $clog2(kdrq_pkg::QUEUE_DEPTH_DEFAULT)
) (
   input  logic                   clock,
   input  logic [1:0]             bank_we,
   input  logic [ADDR_W-1:0]      bank_addr  [2],
   input  kdrq_pkg::key_code_type bank_wdata [2],
   input  logic                   rd_en,
   input  logic                   rd_bank,
   input  logic [ADDR_W-1:0]      rd_addr,
   output kdrq_pkg::key_code_type rd_data
);

   kdrq_pkg::key_code_type bank0_mem [DEPTH];
   kdrq_pkg::key_code_type bank1_mem [DEPTH];
   kdrq_pkg::key_code_type rd_data_ff;

   // write each bank at one address
   always_ff @(posedge clock) begin
      if (bank_we[0]) begin
         bank0_mem[bank_addr[0]] <= bank_wdata[0];
      end
      if (bank_we[1]) begin
         bank1_mem[bank_addr[1]] <= bank_wdata[1];
      end
   end

   // registered read, held until the next pop
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rd_bank ? bank1_mem[rd_addr] : bank0_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/keypad_debounce_repeat_queue_top.sv
// Keypad debounce, auto-repeat and key code queue: one result per request
// transaction. A request enters an input register and its result is computed in
// a single pass into the response register, so one transaction is accepted per
// cycle while the response channel is free and each result is presented on the
// response channel from that register, stalled only by rsp_ready. A scan tick
// (func 0) qualifies the raw byte, debounces it, queues press, release and repeat
// codes (up to two writes in one cycle into a two-bank store) and answers code 0;
// a read (func 1) pops one code, or 0 when empty.
// The queue holds QUEUE_DEPTH-1 codes; codes queued while full are dropped.
// Depends on kdrq_pkg, kdrq_code_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "keypad_debounce_repeat_queue_top_macros.svh"

module keypad_debounce_repeat_queue_top #(
   parameter int QUEUE_DEPTH = kdrq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic [7:0]             req_raw_byte,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output kdrq_pkg::key_code_type rsp_key_code,
   output kdrq_pkg::key_bits_type rsp_pressed_now,
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_wdata
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam int SLOTS = 5;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   // configuration registers
   logic [7:0] debounce_ticks_ff;
   logic [7:0] repeat_delay_ff;
   logic [7:0] repeat_reload_ff;

   // input stage
   logic       in_valid_ff;
   logic       in_func_ff;
   logic [7:0] in_raw_ff;

   // response stage
   logic                   rsp_valid_ff;
   logic                   rsp_pop_ff;
   kdrq_pkg::key_bits_type rsp_pressed_ff;

   // block state
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic                   wr_par_ff, wr_par_in;
   logic                   rd_par_ff, rd_par_in;
   kdrq_pkg::key_bits_type prev_sample_ff, prev_sample_in;
   kdrq_pkg::key_bits_type accepted_ff, accepted_in;
   logic [7:0]             stable_count_ff, stable_count_in;
   kdrq_pkg::key_code_type repeat_code_ff, repeat_code_in;
   logic [7:0]             repeat_count_ff, repeat_count_in;
   logic                   repeat_active_ff, repeat_active_in;
   logic                   up_held_ff, up_held_in;
   logic                   down_held_ff, down_held_in;

   // per-pass signals
   logic                   out_free;
   logic                   advance;
   logic                   is_tick;
   logic                   is_pop;
   logic                   queue_empty;
   kdrq_pkg::key_bits_type sample;
   logic                   key_accept;
   kdrq_pkg::key_bits_type key_on;
   kdrq_pkg::key_bits_type key_off;
   logic [SLOTS-1:0]       slot_req;
   kdrq_pkg::key_code_type slot_code [SLOTS];
   logic [SLOTS-1:0]       slot_ok;
   logic [1:0]             wr_en;
   logic [1:0]             wr_bank;
   logic [PTR_W-1:0]       wr_addr [2];
   kdrq_pkg::key_code_type wr_data [2];
   logic [1:0]             bank_we;
   logic [PTR_W-1:0]       bank_addr [2];
   kdrq_pkg::key_code_type bank_wdata [2];
   kdrq_pkg::key_code_type ram_rd_data;

   // handshakes
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign advance     = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || out_free;
   assign csr_ready   = 1'b1;
   assign is_tick     = advance && (in_func_ff == kdrq_pkg::FUNC_SCAN);
   assign queue_empty = (wr_ptr_ff == rd_ptr_ff);
   assign is_pop      = advance && (in_func_ff == kdrq_pkg::FUNC_READ) && !queue_empty;

   // qualify raw byte: only one-hot key bytes count
   always_comb begin
      if (in_raw_ff == kdrq_pkg::RAW_ESC || in_raw_ff == kdrq_pkg::RAW_UP ||
          in_raw_ff == kdrq_pkg::RAW_DOWN || in_raw_ff == kdrq_pkg::RAW_ENTER) begin
         sample = in_raw_ff[3:0];
      end else begin
         sample = '0;
      end
   end

   // debounce, edge decode, repeat timing and queue pushes
   always_comb begin
      logic [7:0]             sc_inc;
      kdrq_pkg::key_bits_type diff;
      logic                   ra_v;
      logic [7:0]             rcount_v;
      kdrq_pkg::key_code_type rcode_v;
      logic [PTR_W-1:0]       wp_v;
      logic [PTR_W-1:0]       nxt_v;
      logic                   par_v;
      logic                   used0;
      logic                   used1;

      sc_inc = (stable_count_ff == kdrq_pkg::COUNT_MAX) ? stable_count_ff
                                                        : stable_count_ff + 8'd1;
      key_accept = (sample == prev_sample_ff) && (accepted_ff != sample) &&
                   (sc_inc > debounce_ticks_ff);
      diff    = accepted_ff ^ sample;
      key_on  = key_accept ? (diff & sample) : '0;
      key_off = key_accept ? (diff & accepted_ff) : '0;

      ra_v     = repeat_active_ff;
      rcount_v = repeat_count_ff;
      rcode_v  = repeat_code_ff;

      // press of up or down
      slot_req[0]  = key_on[kdrq_pkg::KEY_UP] || key_on[kdrq_pkg::KEY_DOWN];
      slot_code[0] = kdrq_pkg::CODE_DOWN;
      if (key_on[kdrq_pkg::KEY_UP] && key_on[kdrq_pkg::KEY_DOWN]) begin
         slot_code[0] = kdrq_pkg::CODE_UPDOWN;
         ra_v = 1'b0;
      end else if (slot_req[0]) begin
         slot_code[0] = key_on[kdrq_pkg::KEY_UP] ? kdrq_pkg::CODE_UP : kdrq_pkg::CODE_DOWN;
         rcode_v  = slot_code[0];
         rcount_v = '0;
         ra_v     = 1'b1;
      end

      // press of esc or enter
      slot_req[1] = key_on[kdrq_pkg::KEY_ESC] || key_on[kdrq_pkg::KEY_ENTER];
      if (key_on[kdrq_pkg::KEY_ESC] && key_on[kdrq_pkg::KEY_ENTER]) begin
         slot_code[1] = kdrq_pkg::CODE_ESCENTER;
      end else if (key_on[kdrq_pkg::KEY_ESC]) begin
         slot_code[1] = kdrq_pkg::CODE_ESC;
      end else begin
         slot_code[1] = kdrq_pkg::CODE_ENTER;
      end
      if (slot_req[1]) begin
         ra_v = 1'b0;
      end

      // releases of held up or down
      slot_req[2]  = key_off[kdrq_pkg::KEY_UP] && up_held_ff;
      slot_code[2] = kdrq_pkg::CODE_UPOFF;
      slot_req[3]  = key_off[kdrq_pkg::KEY_DOWN] && down_held_ff;
      slot_code[3] = kdrq_pkg::CODE_DOWNOFF;
      if (key_off != '0) begin
         ra_v = 1'b0;
      end

      // auto-repeat
      slot_req[4]  = 1'b0;
      slot_code[4] = rcode_v;
      if (ra_v) begin
         rcount_v = rcount_v + 8'd1;
         if (rcount_v == repeat_delay_ff) begin
            rcount_v    = repeat_reload_ff;
            slot_req[4] = 1'b1;
         end
      end

      // push in order onto the two write ports, dropping when full
      wp_v    = wr_ptr_ff;
      par_v   = wr_par_ff;
      used0   = 1'b0;
      used1   = 1'b0;
      slot_ok = '0;
      wr_en   = '0;
      wr_bank = '0;
      wr_addr[0] = wr_ptr_ff;
      wr_addr[1] = wr_ptr_ff;
      wr_data[0] = kdrq_pkg::CODE_NONE;
      wr_data[1] = kdrq_pkg::CODE_NONE;
      for (int i = 0; i < SLOTS; i++) begin
         nxt_v = ptr_next(wp_v);
         if (is_tick && slot_req[i] && (nxt_v != rd_ptr_ff) && !(used0 && used1)) begin
            slot_ok[i] = 1'b1;
            if (!used0) begin
               used0      = 1'b1;
               wr_en[0]   = 1'b1;
               wr_bank[0] = par_v;
               wr_addr[0] = wp_v;
               wr_data[0] = slot_code[i];
            end else begin
               used1      = 1'b1;
               wr_en[1]   = 1'b1;
               wr_bank[1] = par_v;
               wr_addr[1] = wp_v;
               wr_data[1] = slot_code[i];
            end
            wp_v  = nxt_v;
            par_v = !par_v;
         end
      end

      // next state
      wr_ptr_in        = wr_ptr_ff;
      wr_par_in        = wr_par_ff;
      rd_ptr_in        = rd_ptr_ff;
      rd_par_in        = rd_par_ff;
      prev_sample_in   = prev_sample_ff;
      accepted_in      = accepted_ff;
      stable_count_in  = stable_count_ff;
      repeat_code_in   = repeat_code_ff;
      repeat_count_in  = repeat_count_ff;
      repeat_active_in = repeat_active_ff;
      up_held_in       = up_held_ff;
      down_held_in     = down_held_ff;
      if (is_tick) begin
         wr_ptr_in        = wp_v;
         wr_par_in        = par_v;
         prev_sample_in   = sample;
         repeat_code_in   = rcode_v;
         repeat_count_in  = rcount_v;
         repeat_active_in = ra_v;
         if (sample != prev_sample_ff) begin
            stable_count_in = '0;
         end else if (key_accept) begin
            stable_count_in = '0;
            accepted_in     = sample;
         end else begin
            stable_count_in = sc_inc;
         end
         if (slot_ok[0] && slot_code[0] == kdrq_pkg::CODE_UP) begin
            up_held_in = 1'b1;
         end
         if (slot_ok[0] && slot_code[0] == kdrq_pkg::CODE_DOWN) begin
            down_held_in = 1'b1;
         end
         if (slot_req[2]) begin
            up_held_in = 1'b0;
         end
         if (slot_req[3]) begin
            down_held_in = 1'b0;
         end
      end
      if (is_pop) begin
         rd_ptr_in = ptr_next(rd_ptr_ff);
         rd_par_in = !rd_par_ff;
      end
   end

   // steer write ports to banks; consecutive pushes land in different banks
   always_comb begin
      bank_we       = '0;
      bank_addr[0]  = wr_addr[0];
      bank_addr[1]  = wr_addr[1];
      bank_wdata[0] = wr_data[0];
      bank_wdata[1] = wr_data[1];
      for (int b = 0; b < 2; b++) begin
         if (wr_en[0] && (wr_bank[0] == b[0])) begin
            bank_we[b]    = 1'b1;
            bank_addr[b]  = wr_addr[0];
            bank_wdata[b] = wr_data[0];
         end else if (wr_en[1] && (wr_bank[1] == b[0])) begin
            bank_we[b]    = 1'b1;
            bank_addr[b]  = wr_addr[1];
            bank_wdata[b] = wr_data[1];
         end
      end
   end

   kdrq_code_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (PTR_W)
   ) u_code_ram (
      .clock      (clock),
      .bank_we    (bank_we),
      .bank_addr  (bank_addr),
      .bank_wdata (bank_wdata),
      .rd_en      (is_pop),
      .rd_bank    (rd_par_ff),
      .rd_addr    (rd_ptr_ff),
      .rd_data    (ram_rd_data)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= kdrq_pkg::DEBOUNCE_TICKS_RESET;
         repeat_delay_ff   <= kdrq_pkg::REPEAT_DELAY_RESET;
         repeat_reload_ff  <= kdrq_pkg::REPEAT_RELOAD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            kdrq_pkg::CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wdata;
            kdrq_pkg::CSR_REPEAT_DELAY:   repeat_delay_ff   <= csr_wdata;
            kdrq_pkg::CSR_REPEAT_RELOAD:  repeat_reload_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // hold the request transaction until it advances
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff <= req_func;
         in_raw_ff  <= req_raw_byte;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_pop_ff   <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
         rsp_pop_ff   <= is_pop;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pressed_ff <= prev_sample_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_code    = rsp_pop_ff ? ram_rd_data : kdrq_pkg::CODE_NONE;
   assign rsp_pressed_now = rsp_pressed_ff;

   // advance block state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         wr_par_ff        <= 1'b0;
         rd_par_ff        <= 1'b0;
         prev_sample_ff   <= '0;
         accepted_ff      <= '0;
         stable_count_ff  <= '0;
         repeat_code_ff   <= kdrq_pkg::CODE_NONE;
         repeat_count_ff  <= '0;
         repeat_active_ff <= 1'b0;
         up_held_ff       <= 1'b0;
         down_held_ff     <= 1'b0;
      end else begin
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         wr_par_ff        <= wr_par_in;
         rd_par_ff        <= rd_par_in;
         prev_sample_ff   <= prev_sample_in;
         accepted_ff      <= accepted_in;
         stable_count_ff  <= stable_count_in;
         repeat_code_ff   <= repeat_code_in;
         repeat_count_ff  <= repeat_count_in;
         repeat_active_ff <= repeat_active_in;
         up_held_ff       <= up_held_in;
         down_held_ff     <= down_held_in;
      end
   end

   // checks
   `KDRQ_ASSERT_NOW(a_empty_bank_align, wr_ptr_ff == rd_ptr_ff, wr_par_ff == rd_par_ff,
      "bank parity out of step with pointers")
   `KDRQ_ASSERT_NOW(a_up_held_key, up_held_ff,
      accepted_ff == kdrq_pkg::key_bits_type'(kdrq_pkg::RAW_UP),
      "up held without up key accepted")
   `KDRQ_ASSERT_NOW(a_down_held_key, down_held_ff,
      accepted_ff == kdrq_pkg::key_bits_type'(kdrq_pkg::RAW_DOWN),
      "down held without down key accepted")
   `KDRQ_ASSERT_NEXT(a_empty_read_zero,
      advance && in_func_ff == kdrq_pkg::FUNC_READ && queue_empty,
      rsp_key_code == kdrq_pkg::CODE_NONE, "read of empty queue returned a code")
   `KDRQ_ASSERT_NEXT(a_tick_pattern, is_tick, rsp_pressed_now == $past(sample),
      "pressed pattern does not follow scan tick")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for keypad_debounce_repeat_queue_top: drives scan and read transactions,
// predicts every response with its own model of debounce, auto-repeat and code queue.
// Depends on kdrq_pkg and the keypad_debounce_repeat_queue_top RTL.

module tb_top;

   localparam int DEPTH         = kdrq_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 6;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_func = kdrq_pkg::FUNC_SCAN;
   logic [7:0] req_raw_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   kdrq_pkg::key_code_type rsp_key_code;
   kdrq_pkg::key_bits_type rsp_pressed_now;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = kdrq_pkg::CSR_DEBOUNCE_TICKS;
   logic [7:0] csr_wdata = 8'd0;

   // Model state: code queue, debounce and repeat
   logic [3:0]             fifo_codes [DEPTH];
   int unsigned            fifo_wr = 0;
   int unsigned            fifo_rd = 0;
   kdrq_pkg::key_bits_type last_pattern = '0;
   kdrq_pkg::key_bits_type debounced = '0;
   logic [7:0]             steady_ticks = 8'd0;
   logic [7:0]             repeat_ticks = 8'd0;
   kdrq_pkg::key_code_type repeat_key = kdrq_pkg::CODE_NONE;
   bit                     repeating = 1'b0;
   bit                     up_latched = 1'b0;
   bit                     down_latched = 1'b0;
   logic [7:0]             cfg_debounce = kdrq_pkg::DEBOUNCE_TICKS_RESET;
   logic [7:0]             cfg_delay = kdrq_pkg::REPEAT_DELAY_RESET;
   logic [7:0]             cfg_reload = kdrq_pkg::REPEAT_RELOAD_RESET;

   // Expected responses, oldest first
   kdrq_pkg::key_code_type pending_codes [$];
   kdrq_pkg::key_bits_type pending_patterns [$];

   int          send_gap_pct = 16;
   int          recv_stall_pct = 79;
   int          items_sent = 0;
   int          fail_count = 0;
   int unsigned cycle_count = 0;
   kdrq_pkg::key_code_type want_code;
   kdrq_pkg::key_bits_type want_keys;

   keypad_debounce_repeat_queue_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_raw_byte    (req_raw_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key_code    (rsp_key_code),
      .rsp_pressed_now (rsp_pressed_now),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Push a code unless the queue is full; report whether it was stored
   function automatic bit queue_code(kdrq_pkg::key_code_type code);
      int unsigned nxt;
      nxt = (fifo_wr + 1) % DEPTH;
      if (nxt == fifo_rd) return 1'b0;
      fifo_codes[fifo_wr] = code;
      fifo_wr = nxt;
      return 1'b1;
   endfunction

   // Queue press codes first, then release codes
   function automatic void take_edges(kdrq_pkg::key_bits_type pressed,
                                      kdrq_pkg::key_bits_type released);
      if (pressed != '0) begin
         if (pressed[kdrq_pkg::KEY_UP] && pressed[kdrq_pkg::KEY_DOWN]) begin
            void'(queue_code(kdrq_pkg::CODE_UPDOWN));
            repeating = 1'b0;
         end else if (pressed[kdrq_pkg::KEY_UP] || pressed[kdrq_pkg::KEY_DOWN]) begin
            if (pressed[kdrq_pkg::KEY_UP]) begin
               if (queue_code(kdrq_pkg::CODE_UP)) up_latched = 1'b1;
               repeat_key = kdrq_pkg::CODE_UP;
            end else begin
               if (queue_code(kdrq_pkg::CODE_DOWN)) down_latched = 1'b1;
               repeat_key = kdrq_pkg::CODE_DOWN;
            end
            repeat_ticks = 8'd0;
            repeating = 1'b1;
         end
         if (pressed[kdrq_pkg::KEY_ESC] && pressed[kdrq_pkg::KEY_ENTER]) begin
            void'(queue_code(kdrq_pkg::CODE_ESCENTER));
            repeating = 1'b0;
         end else if (pressed[kdrq_pkg::KEY_ESC] || pressed[kdrq_pkg::KEY_ENTER]) begin
            void'(queue_code(pressed[kdrq_pkg::KEY_ESC] ? kdrq_pkg::CODE_ESC
                                                        : kdrq_pkg::CODE_ENTER));
            repeating = 1'b0;
         end
      end
      if (released != '0) begin
         if (released[kdrq_pkg::KEY_UP] && up_latched) begin
            void'(queue_code(kdrq_pkg::CODE_UPOFF));
            up_latched = 1'b0;
         end
         if (released[kdrq_pkg::KEY_DOWN] && down_latched) begin
            void'(queue_code(kdrq_pkg::CODE_DOWNOFF));
            down_latched = 1'b0;
         end
         repeating = 1'b0;
      end
   endfunction

   // Qualify, debounce and repeat on one scan tick
   function automatic void scan_keys(logic [7:0] raw);
      kdrq_pkg::key_bits_type pattern;
      kdrq_pkg::key_bits_type delta;
      pattern = '0;
      if (raw == kdrq_pkg::RAW_ESC || raw == kdrq_pkg::RAW_UP ||
          raw == kdrq_pkg::RAW_DOWN || raw == kdrq_pkg::RAW_ENTER)
         pattern = raw[3:0];
      if (pattern == last_pattern) begin
         if (steady_ticks != kdrq_pkg::COUNT_MAX) steady_ticks = steady_ticks + 8'd1;
         if (debounced != pattern && steady_ticks > cfg_debounce) begin
            delta = debounced ^ pattern;
            steady_ticks = 8'd0;
            take_edges(delta & pattern, delta & debounced);
            debounced = pattern;
         end
      end else begin
         steady_ticks = 8'd0;
      end
      if (repeating) begin
         repeat_ticks = repeat_ticks + 8'd1;
         if (repeat_ticks == cfg_delay) begin
            repeat_ticks = cfg_reload;
            void'(queue_code(repeat_key));
         end
      end
      last_pattern = pattern;
   endfunction

   // Advance the model by one transaction and record its response
   function automatic void predict_response(logic func, logic [7:0] raw);
      kdrq_pkg::key_code_type popped;
      popped = kdrq_pkg::CODE_NONE;
      if (func == kdrq_pkg::FUNC_SCAN) begin
         scan_keys(raw);
      end else if (fifo_wr != fifo_rd) begin
         popped = fifo_codes[fifo_rd];
         fifo_rd = (fifo_rd + 1) % DEPTH;
      end
      pending_codes.push_back(popped);
      pending_patterns.push_back(last_pattern);
   endfunction

   // Check each response transaction, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            $error("response with nothing pending: key_code %0d pressed_now %0h",
                   rsp_key_code, rsp_pressed_now);
            fail_count++;
         end else begin
            want_code = pending_codes.pop_front();
            want_keys = pending_patterns.pop_front();
            if (rsp_key_code !== want_code) begin
               $error("key_code: expected %0d, got %0d", want_code, rsp_key_code);
               fail_count++;
            end
            if (rsp_pressed_now !== want_keys) begin
               $error("pressed_now: expected %0h, got %0h", want_keys, rsp_pressed_now);
               fail_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Send one request transaction, with random gaps ahead of it
   task automatic send_item(logic func, logic [7:0] raw);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_raw_byte <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_response(func, raw);
      items_sent++;
   endtask

   // Hold the sender until every expected response has arrived
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(kdrq_pkg::csr_index_type idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         kdrq_pkg::CSR_DEBOUNCE_TICKS: cfg_debounce = val;
         kdrq_pkg::CSR_REPEAT_DELAY:   cfg_delay = val;
         kdrq_pkg::CSR_REPEAT_RELOAD:  cfg_reload = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(int deb, int dly, int rld);
      wait_idle();
      write_csr(kdrq_pkg::CSR_DEBOUNCE_TICKS, 8'(deb));
      write_csr(kdrq_pkg::CSR_REPEAT_DELAY, 8'(dly));
      write_csr(kdrq_pkg::CSR_REPEAT_RELOAD, 8'(rld));
   endtask

   task automatic hold_key(logic [7:0] raw, int ticks);
      repeat (ticks) send_item(kdrq_pkg::FUNC_SCAN, raw);
   endtask

   // Empty read, noise, every key, repeat, and a change from up straight to down
   task automatic test_key_codes();
      send_item(kdrq_pkg::FUNC_READ, 8'h00);
      send_item(kdrq_pkg::FUNC_SCAN, 8'hFF);
      send_item(kdrq_pkg::FUNC_SCAN, 8'h00);
      set_config(0, 2, 0);
      hold_key(kdrq_pkg::RAW_UP, 3);
      hold_key(kdrq_pkg::RAW_DOWN, 2);
      hold_key(8'h03, 2);
      hold_key(kdrq_pkg::RAW_ESC, 2);
      hold_key(kdrq_pkg::RAW_ENTER, 2);
      send_item(kdrq_pkg::FUNC_SCAN, 8'h00);
      repeat (9) send_item(kdrq_pkg::FUNC_READ, 8'hFF);
   endtask

   // Saturated stable count never exceeds the longest debounce
   task automatic test_long_debounce();
      set_config(kdrq_pkg::COUNT_MAX, kdrq_pkg::REPEAT_DELAY_RESET,
                 kdrq_pkg::REPEAT_RELOAD_RESET);
      hold_key(kdrq_pkg::RAW_UP, 260);
      repeat (2) send_item(kdrq_pkg::FUNC_READ, 8'h00);
   endtask

   // Repeat on every tick until codes are dropped, then drain past empty
   task automatic test_queue_full();
      set_config(0, 1, 0);
      hold_key(kdrq_pkg::RAW_UP, 20);
      hold_key(8'h00, 2);
      repeat (DEPTH + 1) send_item(kdrq_pkg::FUNC_READ, 8'h00);
   endtask

   // Mostly well-formed key holds with random content, read bursts and noise
   task automatic test_random(int send_pct, int recv_pct, int count);
      int stop_at;
      int seg_end;
      int choice;
      int hold;
      int deb;
      int dly;
      int rld;
      logic [7:0] key;
      send_gap_pct = send_pct;
      recv_stall_pct = recv_pct;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         deb = $urandom_range(0, 6);
         case ($urandom_range(3))
            0: begin
               dly = $urandom_range(1, 8);
               rld = $urandom_range(0, dly - 1);
            end
            1: begin
               // reload at or past the delay: counter wraps before repeating
               dly = $urandom_range(1, 8);
               rld = $urandom_range(dly, 254);
            end
            2: begin
               dly = 255;
               rld = 254;
            end
            default: begin
               dly = 1;
               rld = 0;
            end
         endcase
         set_config(deb, dly, rld);
         seg_end = items_sent + $urandom_range(100, 200);
         while (items_sent < seg_end && items_sent < stop_at) begin
            choice = $urandom_range(99);
            if (choice < 20) begin
               repeat ($urandom_range(1, 6))
                  send_item(kdrq_pkg::FUNC_READ, 8'($urandom_range(0, 255)));
            end else if (choice < 88) begin
               case ($urandom_range(4))
                  0: key = kdrq_pkg::RAW_ESC;
                  1: key = kdrq_pkg::RAW_UP;
                  2: key = kdrq_pkg::RAW_DOWN;
                  3: key = kdrq_pkg::RAW_ENTER;
                  default: key = 8'h00;
               endcase
               hold = $urandom_range(1, deb + 3);
               if ($urandom_range(3) == 0) hold += $urandom_range(0, 40);
               hold_key(key, hold);
            end else begin
               send_item(kdrq_pkg::FUNC_SCAN, 8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_key_codes();
      test_long_debounce();
      test_queue_full();
      test_random(16, 79, 510);
      test_random(79, 16, 510);
      test_random(0, 0, 510);
      wait_idle();
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
